### rtl/core/nlt_pkg.sv
// Shared types and constants for the node liveness table.
`timescale 1ns / 1ps
`default_nettype none

package nlt_pkg;

    localparam int NODES = 16;
    localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CNT_W = IDX_W + 1;

    localparam int ID_W    = 64;
    localparam int TIME_W  = 32;
    localparam int TOTAL_W = 32;
    localparam int TYPE_W  = 6;
    localparam int DTO_W   = 16;
    localparam int CTO_W   = 20;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [DTO_W-1:0] DEAD_TIMEOUT_RST  = DTO_W'(90);
    localparam logic [CTO_W-1:0] CLEAR_TIMEOUT_RST = CTO_W'(600 * 5);

    localparam logic [CFG_IDX_W-1:0] REG_OWN_ID        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KNOWN_TYPES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIMEOUT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_TIMEOUT = 2'd3;

    typedef enum logic [2:0] {
        KIND_ADD        = 3'd0,
        KIND_RECEIVE    = 3'd1,
        KIND_RETRANSMIT = 3'd2,
        KIND_TICK       = 3'd3,
        KIND_DEAD_CHECK = 3'd4,
        KIND_STATS      = 3'd5,
        KIND_SET_DEAD   = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        STATUS_OK           = 3'd0,
        STATUS_IGNORED_DEAD = 3'd1,
        STATUS_UNKNOWN_NODE = 3'd2,
        STATUS_DUPLICATE    = 3'd3,
        STATUS_OWN_ID       = 3'd4,
        STATUS_UNKNOWN_TYPE = 3'd5,
        STATUS_FULL         = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        NOTICE_NONE    = 2'd0,
        NOTICE_INCLUDE = 2'd1,
        NOTICE_EXCLUDE = 2'd2
    } notice_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CLOSE
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic               dead;
        logic [TIME_W-1:0]  last_rx;
        logic [TOTAL_W-1:0] rx_count;
        logic [TOTAL_W-1:0] retx_count;
        logic               has_stats;
    } entry_t;

    typedef struct packed {
        status_t            status;
        notice_t            notice;
        logic [ID_W-1:0]    peer_id;
        logic [TOTAL_W-1:0] receive_total;
        logic [TOTAL_W-1:0] retransmit_total;
        logic               dead_flag;
        logic               changed;
        logic               last_result;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/node_liveness_table.sv
// Peer liveness table: add, receive, retransmit, stats, set-dead, tick and dead check.
`timescale 1ns / 1ps
`default_nettype none
//
// Usage: drive kind, node_id, node_type and parse_ok with start high; the word is
// taken at a clock edge where busy is low. Each result word appears for exactly one
// cycle with result_valid high; the final word of an item carries last_result.
// Tick, an unused kind and an add of the own id answer in the cycle after the start
// and leave busy low, so one of these can be issued every cycle.
// Every other kind walks the entry memory, one read per cycle with the read data
// registered; busy stays high until the final word of the item is issued. A lookup
// stops at the entry that matches; add and dead check always walk the whole table.
// A dead check emits one exclude word per killed node, in slot order, then a
// closing word. The entry memory is the limit on rate: one port read per cycle.
// Configuration (cfg_we, cfg_index, cfg_wdata) takes effect at once; write it only
// while busy is low and no result is pending.
// Reset clears time, the valid bits and the configuration to its defaults; entry
// contents are written on add, so no clearing pass is needed. The receiver cannot
// stall: results are never held back.
//

module node_liveness_table (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  kind,
    input  wire logic signed [63:0] node_id,
    input  wire logic [5:0]  node_type,
    input  wire logic        parse_ok,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata,
    output logic             result_valid,
    output logic [2:0]       status,
    output logic [1:0]       notice,
    output logic signed [63:0] peer_id,
    output logic [31:0]      receive_total,
    output logic [31:0]      retransmit_total,
    output logic             dead_flag,
    output logic             changed,
    output logic             last_result
);
    import nlt_pkg::*;

    state_t                state_reg, state_next;
    kind_t                 op_kind_reg, op_kind_next;
    logic [ID_W-1:0]       op_id_reg, op_id_next;
    logic [TYPE_W-1:0]     op_type_reg, op_type_next;
    logic                  op_parse_reg, op_parse_next;
    logic [CNT_W-1:0]      issue_addr_reg, issue_addr_next;
    logic                  eval_vld_reg, eval_vld_next;
    logic [IDX_W-1:0]      eval_idx_reg, eval_idx_next;
    logic                  dup_reg, dup_next;
    logic                  free_found_reg, free_found_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic                  any_kill_reg, any_kill_next;
    logic [TIME_W-1:0]     time_now_reg, time_now_next;
    logic [NODES-1:0]      valid_reg, valid_next;
    logic [ID_W-1:0]       own_id_reg;
    logic [63:0]           known_types_reg;
    logic [DTO_W-1:0]      dead_timeout_reg;
    logic [CTO_W-1:0]      clear_timeout_reg;
    result_t               result_reg, result_next;
    logic                  result_valid_reg, result_valid_next;

    entry_t                mem [NODES];
    entry_t                rd_data_reg;
    entry_t                entry_upd;
    entry_t                mem_wdata;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic                  rd_en;

    logic                  accept;
    logic                  hit;
    logic                  slot_valid;
    logic                  last_idx;
    logic                  is_lookup;
    logic [TIME_W-1:0]     age;

    assign busy       = (state_reg != S_IDLE);
    assign accept     = start && !busy;
    assign slot_valid = valid_reg[eval_idx_reg];
    assign hit        = slot_valid && (rd_data_reg.id == op_id_reg);
    assign last_idx   = (eval_idx_reg == IDX_W'(NODES - 1));
    assign age        = time_now_reg - rd_data_reg.last_rx;
    assign is_lookup  = op_kind_reg inside {KIND_RECEIVE, KIND_RETRANSMIT, KIND_STATS,
                                            KIND_SET_DEAD};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (kind_t'(kind))
                        KIND_ADD:
                            state_next = (node_id == own_id_reg) ? S_IDLE : S_SCAN;
                        KIND_RECEIVE, KIND_RETRANSMIT, KIND_DEAD_CHECK, KIND_STATS,
                        KIND_SET_DEAD:
                            state_next = S_SCAN;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (eval_vld_reg)
                begin
                    if (is_lookup && hit)
                        state_next = S_IDLE;
                    else if (last_idx)
                        state_next = S_CLOSE;
                end
            end
            S_CLOSE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Datapath, memory port and result word
    always_comb
    begin
        op_kind_next      = op_kind_reg;
        op_id_next        = op_id_reg;
        op_type_next      = op_type_reg;
        op_parse_next     = op_parse_reg;
        issue_addr_next   = issue_addr_reg;
        eval_vld_next     = 1'b0;
        eval_idx_next     = eval_idx_reg;
        dup_next          = dup_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        any_kill_next     = any_kill_reg;
        time_now_next     = time_now_reg;
        valid_next        = valid_reg;
        mem_we            = 1'b0;
        mem_waddr         = eval_idx_reg;
        mem_wdata         = rd_data_reg;
        rd_en             = 1'b0;
        entry_upd         = rd_data_reg;
        result_valid_next = 1'b0;
        result_next       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_kind_next    = kind_t'(kind);
                    op_id_next      = node_id;
                    op_type_next    = node_type;
                    op_parse_next   = parse_ok;
                    issue_addr_next = '0;
                    dup_next        = 1'b0;
                    free_found_next = 1'b0;
                    free_idx_next   = '0;
                    any_kill_next   = 1'b0;
                    case (kind_t'(kind))
                        KIND_TICK:
                        begin
                            time_now_next           = time_now_reg + 1'b1;
                            result_valid_next       = 1'b1;
                            result_next.last_result = 1'b1;
                        end
                        KIND_ADD:
                        begin
                            if (node_id == own_id_reg)
                            begin
                                result_valid_next       = 1'b1;
                                result_next.status      = STATUS_OWN_ID;
                                result_next.peer_id     = node_id;
                                result_next.last_result = 1'b1;
                            end
                        end
                        KIND_RECEIVE, KIND_RETRANSMIT, KIND_DEAD_CHECK, KIND_STATS,
                        KIND_SET_DEAD:
                        begin
                        end
                        default:
                        begin
                            result_valid_next       = 1'b1;
                            result_next.last_result = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Issue one read per cycle; evaluate the previous slot's data.
                if (issue_addr_reg < CNT_W'(NODES))
                begin
                    rd_en           = 1'b1;
                    issue_addr_next = issue_addr_reg + 1'b1;
                    eval_vld_next   = 1'b1;
                    eval_idx_next   = issue_addr_reg[IDX_W-1:0];
                end

                if (eval_vld_reg)
                begin
                    case (op_kind_reg)
                        KIND_ADD:
                        begin
                            if (hit)
                                dup_next = 1'b1;
                            if (!slot_valid && !free_found_reg)
                            begin
                                free_found_next = 1'b1;
                                free_idx_next   = eval_idx_reg;
                            end
                        end
                        KIND_DEAD_CHECK:
                        begin
                            if (slot_valid)
                            begin
                                if (!rd_data_reg.dead && age > TIME_W'(dead_timeout_reg))
                                begin
                                    entry_upd.dead               = 1'b1;
                                    mem_we                       = 1'b1;
                                    mem_wdata                    = entry_upd;
                                    any_kill_next                = 1'b1;
                                    result_valid_next            = 1'b1;
                                    result_next.status           = STATUS_OK;
                                    result_next.notice           = NOTICE_EXCLUDE;
                                    result_next.peer_id          = rd_data_reg.id;
                                    result_next.receive_total    = rd_data_reg.rx_count;
                                    result_next.retransmit_total = rd_data_reg.retx_count;
                                    result_next.dead_flag        = 1'b1;
                                end
                                else if (rd_data_reg.dead &&
                                         age > TIME_W'(clear_timeout_reg) &&
                                         rd_data_reg.has_stats)
                                begin
                                    entry_upd.has_stats = 1'b0;
                                    mem_we              = 1'b1;
                                    mem_wdata           = entry_upd;
                                end
                            end
                        end
                        KIND_RECEIVE, KIND_RETRANSMIT, KIND_STATS, KIND_SET_DEAD:
                        begin
                            if (hit)
                            begin
                                result_valid_next       = 1'b1;
                                result_next.status      = STATUS_OK;
                                result_next.last_result = 1'b1;
                                if (op_kind_reg == KIND_SET_DEAD)
                                begin
                                    entry_upd.dead = 1'b1;
                                    mem_we         = 1'b1;
                                end
                                else if (rd_data_reg.dead)
                                begin
                                    // Drop events for dead peers.
                                    result_next.status = STATUS_IGNORED_DEAD;
                                end
                                else
                                begin
                                    mem_we = 1'b1;
                                    if (op_kind_reg == KIND_RECEIVE)
                                    begin
                                        entry_upd.rx_count = rd_data_reg.rx_count + 1'b1;
                                        entry_upd.last_rx  = time_now_reg;
                                    end
                                    else if (op_kind_reg == KIND_RETRANSMIT)
                                        entry_upd.retx_count = rd_data_reg.retx_count + 1'b1;
                                    else
                                        entry_upd.has_stats = op_parse_reg;
                                end
                                mem_wdata                    = entry_upd;
                                result_next.peer_id          = entry_upd.id;
                                result_next.receive_total    = entry_upd.rx_count;
                                result_next.retransmit_total = entry_upd.retx_count;
                                result_next.dead_flag        = entry_upd.dead;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_CLOSE:
            begin
                result_valid_next       = 1'b1;
                result_next.last_result = 1'b1;
                case (op_kind_reg)
                    KIND_DEAD_CHECK:
                        result_next.changed = any_kill_reg;
                    KIND_ADD:
                    begin
                        result_next.peer_id = op_id_reg;
                        if (dup_reg)
                            result_next.status = STATUS_DUPLICATE;
                        else if (!known_types_reg[op_type_reg])
                            result_next.status = STATUS_UNKNOWN_TYPE;
                        else if (!free_found_reg)
                            result_next.status = STATUS_FULL;
                        else
                        begin
                            mem_we                   = 1'b1;
                            mem_waddr                = free_idx_reg;
                            mem_wdata                = '0;
                            mem_wdata.id             = op_id_reg;
                            mem_wdata.last_rx        = time_now_reg;
                            valid_next[free_idx_reg] = 1'b1;
                            result_next.status       = STATUS_OK;
                            result_next.notice       = NOTICE_INCLUDE;
                            result_next.changed      = 1'b1;
                        end
                    end
                    default:
                    begin
                        result_next.status  = STATUS_UNKNOWN_NODE;
                        result_next.peer_id = op_id_reg;
                    end
                endcase
            end

            default:
            begin
            end
        endcase
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            issue_addr_reg    <= '0;
            eval_vld_reg      <= 1'b0;
            eval_idx_reg      <= '0;
            dup_reg           <= 1'b0;
            free_found_reg    <= 1'b0;
            free_idx_reg      <= '0;
            any_kill_reg      <= 1'b0;
            time_now_reg      <= '0;
            valid_reg         <= '0;
            result_valid_reg  <= 1'b0;
            own_id_reg        <= '0;
            known_types_reg   <= '1;
            dead_timeout_reg  <= DEAD_TIMEOUT_RST;
            clear_timeout_reg <= CLEAR_TIMEOUT_RST;
        end
        else
        begin
            state_reg        <= state_next;
            issue_addr_reg   <= issue_addr_next;
            eval_vld_reg     <= eval_vld_next;
            eval_idx_reg     <= eval_idx_next;
            dup_reg          <= dup_next;
            free_found_reg   <= free_found_next;
            free_idx_reg     <= free_idx_next;
            any_kill_reg     <= any_kill_next;
            time_now_reg     <= time_now_next;
            valid_reg        <= valid_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OWN_ID:        own_id_reg        <= cfg_wdata;
                    REG_KNOWN_TYPES:   known_types_reg   <= cfg_wdata;
                    REG_DEAD_TIMEOUT:  dead_timeout_reg  <= cfg_wdata[DTO_W-1:0];
                    REG_CLEAR_TIMEOUT: clear_timeout_reg <= cfg_wdata[CTO_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_kind_reg  <= op_kind_next;
        op_id_reg    <= op_id_next;
        op_type_reg  <= op_type_next;
        op_parse_reg <= op_parse_next;
        result_reg   <= result_next;
    end

    // Entry memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            rd_data_reg <= mem[issue_addr_reg[IDX_W-1:0]];
    end

    assign result_valid     = result_valid_reg;
    assign status           = result_reg.status;
    assign notice           = result_reg.notice;
    assign peer_id          = result_reg.peer_id;
    assign receive_total    = result_reg.receive_total;
    assign retransmit_total = result_reg.retransmit_total;
    assign dead_flag        = result_reg.dead_flag;
    assign changed          = result_reg.changed;
    assign last_result      = result_reg.last_result;

endmodule

`default_nettype wire

### rtl/core/nlt_checker.sv
// Port-level checks for the node liveness table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module nlt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [2:0]  kind,
    input wire logic        result_valid,
    input wire logic [2:0]  status,
    input wire logic [1:0]  notice,
    input wire logic        dead_flag,
    input wire logic        last_result
);
    import nlt_pkg::*;

    // A tick answers in the next cycle and never blocks the next word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_TICK) |=> (result_valid && last_result && !busy))
    else $error("tick did not answer in one cycle");

    // Only dead check kills produce non-final words.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_result) |->
            (notice == NOTICE_EXCLUDE && dead_flag && status == STATUS_OK))
    else $error("non-final word is not an exclude notice");

    // A non-final word means the scan still runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_result) |-> busy)
    else $error("non-final word while idle");

    // Leaving a scan always delivers the final word.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (result_valid && last_result))
    else $error("scan ended without a final word");

endmodule

bind node_liveness_table nlt_checker u_nlt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .result_valid (result_valid),
    .status       (status),
    .notice       (notice),
    .dead_flag    (dead_flag),
    .last_result  (last_result)
);

`default_nettype wire

### tb/node_liveness_table_tb.sv
// Self-checking testbench for the node liveness table: directed table, then randomized phases.
`timescale 1ns / 1ps

module node_liveness_table_tb;

    import nlt_pkg::*;

    localparam logic [2:0]  KIND_UNUSED   = 3'd7;
    localparam int          POOL          = 22;
    localparam int          SETTLE_CYCLES = NODES + 4;
    localparam int          HIDDEN_TYPE   = 13;
    localparam logic [63:0] ID_MAX        = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ID_MIN        = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ID_ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [2:0]  k;
        logic [63:0] id;
        logic [5:0]  ty;
        logic        ok;
        bit          typed;
        result_t     want;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         kind;
    logic signed [63:0] node_id;
    logic [5:0]         node_type;
    logic               parse_ok;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [63:0]        cfg_wdata;
    logic               result_valid;
    logic [2:0]         status;
    logic [1:0]         notice;
    logic signed [63:0] peer_id;
    logic [31:0]        receive_total;
    logic [31:0]        retransmit_total;
    logic               dead_flag;
    logic               changed;
    logic               last_result;

    // table image kept in step with the block
    logic [63:0] cur_own_id;
    logic [63:0] cur_type_mask;
    logic [15:0] cur_dead_to;
    logic [19:0] cur_clear_to;
    logic [31:0] tnow;
    logic        slot_valid   [NODES];
    logic [63:0] slot_id      [NODES];
    logic        slot_dead    [NODES];
    logic [31:0] slot_last_rx [NODES];
    logic [31:0] slot_rx      [NODES];
    logic [31:0] slot_retx    [NODES];
    logic        slot_stats   [NODES];

    result_t     reply_words [$];
    stim_row_t   script [$];
    logic [63:0] id_pool [POOL];
    result_t     want_word;
    bit          no_gaps = 1'b0;
    int          fail_count = 0;

    node_liveness_table i_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t mk_word(status_t st, notice_t nt, logic [63:0] id,
                                        logic [31:0] rx, logic [31:0] rt, logic dd,
                                        logic ch, logic lr);
        result_t w;
        w.status           = st;
        w.notice           = nt;
        w.peer_id          = id;
        w.receive_total    = rx;
        w.retransmit_total = rt;
        w.dead_flag        = dd;
        w.changed          = ch;
        w.last_result      = lr;
        return w;
    endfunction

    // append one word to the list of words the block owes
    task automatic owe_word(input result_t w);
        reply_words.insert(reply_words.size(), w);
    endtask

    task automatic table_event(input logic [2:0] k, input logic [63:0] id,
                               input logic [5:0] ty, input logic ok);
        int          s;
        int          free_s;
        int          i;
        logic        any_kill;
        logic [31:0] age;
        status_t     st;
        s        = -1;
        free_s   = -1;
        any_kill = 1'b0;
        for (i = 0; i < NODES; i++)
            if (s < 0 && slot_valid[i] && slot_id[i] == id)
                s = i;
        for (i = NODES - 1; i >= 0; i--)
            if (!slot_valid[i])
                free_s = i;
        case (k)
            KIND_TICK:
            begin
                tnow = tnow + 32'd1;
                owe_word(mk_word(STATUS_OK, NOTICE_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b1));
            end
            KIND_DEAD_CHECK:
            begin
                for (i = 0; i < NODES; i++)
                begin
                    if (slot_valid[i])
                    begin
                        age = tnow - slot_last_rx[i];
                        if (!slot_dead[i] && age > cur_dead_to)
                        begin
                            slot_dead[i] = 1'b1;
                            any_kill     = 1'b1;
                            owe_word(mk_word(STATUS_OK, NOTICE_EXCLUDE, slot_id[i],
                                             slot_rx[i], slot_retx[i], 1'b1, 1'b0, 1'b0));
                        end
                        else if (slot_dead[i] && age > cur_clear_to)
                            slot_stats[i] = 1'b0;
                    end
                end
                owe_word(mk_word(STATUS_OK, NOTICE_NONE, '0, '0, '0, 1'b0, any_kill, 1'b1));
            end
            KIND_ADD:
            begin
                if (id == cur_own_id)
                    owe_word(mk_word(STATUS_OWN_ID, NOTICE_NONE, id, '0, '0,
                                     1'b0, 1'b0, 1'b1));
                else if (s >= 0)
                    owe_word(mk_word(STATUS_DUPLICATE, NOTICE_NONE, id, '0, '0,
                                     1'b0, 1'b0, 1'b1));
                else if (!cur_type_mask[ty])
                    owe_word(mk_word(STATUS_UNKNOWN_TYPE, NOTICE_NONE, id, '0, '0,
                                     1'b0, 1'b0, 1'b1));
                else if (free_s < 0)
                    owe_word(mk_word(STATUS_FULL, NOTICE_NONE, id, '0, '0,
                                     1'b0, 1'b0, 1'b1));
                else
                begin
                    slot_valid[free_s]   = 1'b1;
                    slot_id[free_s]      = id;
                    slot_dead[free_s]    = 1'b0;
                    slot_last_rx[free_s] = tnow;
                    slot_rx[free_s]      = '0;
                    slot_retx[free_s]    = '0;
                    slot_stats[free_s]   = 1'b0;
                    owe_word(mk_word(STATUS_OK, NOTICE_INCLUDE, id, '0, '0,
                                     1'b0, 1'b1, 1'b1));
                end
            end
            KIND_UNUSED:
                owe_word(mk_word(STATUS_OK, NOTICE_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b1));
            default:
            begin
                if (s < 0)
                    owe_word(mk_word(STATUS_UNKNOWN_NODE, NOTICE_NONE, id, '0, '0,
                                     1'b0, 1'b0, 1'b1));
                else
                begin
                    st = STATUS_OK;
                    if (k == KIND_SET_DEAD)
                        slot_dead[s] = 1'b1;
                    else if (slot_dead[s])
                        st = STATUS_IGNORED_DEAD;
                    else if (k == KIND_RECEIVE)
                    begin
                        slot_rx[s]      = slot_rx[s] + 32'd1;
                        slot_last_rx[s] = tnow;
                    end
                    else if (k == KIND_RETRANSMIT)
                        slot_retx[s] = slot_retx[s] + 32'd1;
                    else
                        slot_stats[s] = ok;
                    owe_word(mk_word(st, NOTICE_NONE, slot_id[s], slot_rx[s],
                                     slot_retx[s], slot_dead[s], 1'b0, 1'b1));
                end
            end
        endcase
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_OWN_ID:        cur_own_id    = val;
            REG_KNOWN_TYPES:   cur_type_mask = val;
            REG_DEAD_TIMEOUT:  cur_dead_to   = val[15:0];
            REG_CLEAR_TIMEOUT: cur_clear_to  = val[19:0];
            default:           ;
        endcase
    endtask

    // drop start, wait for every owed word, then let the block go quiet
    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (reply_words.size() != 0 || busy)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_item(input logic [2:0] k, input logic [63:0] id, input logic [5:0] ty,
                             input logic ok, input bit typed, input result_t want);
        int gap;
        int n0;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     = 1'b1;
        kind      = k;
        node_id   = id;
        node_type = ty;
        parse_ok  = ok;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        n0 = reply_words.size();
        table_event(k, id, ty, ok);
        // keep the table image in step, but hold the hand-written word for this row
        if (typed)
        begin
            while (reply_words.size() > n0)
                reply_words.delete(reply_words.size() - 1);
            owe_word(want);
        end
    endtask

    task automatic script_row(input logic [2:0] k, input logic [63:0] id, input logic [5:0] ty,
                              input logic ok, input bit typed, input result_t want);
        stim_row_t r;
        r.k     = k;
        r.id    = id;
        r.ty    = ty;
        r.ok    = ok;
        r.typed = typed;
        r.want  = want;
        script.insert(script.size(), r);
    endtask

    task automatic random_item(input int add_w);
        int          r;
        logic [2:0]  k;
        logic [63:0] id;
        r = $urandom_range(0, 99);
        if (r < add_w)
            k = KIND_ADD;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                k = KIND_RECEIVE;
            else if (r < 45)
                k = KIND_RETRANSMIT;
            else if (r < 65)
                k = KIND_TICK;
            else if (r < 78)
                k = KIND_DEAD_CHECK;
            else if (r < 97)
                k = KIND_STATS;
            else
                k = KIND_SET_DEAD;
        end
        // mostly known peers, some stray ids
        if ($urandom_range(0, 9) == 0)
            id = {$urandom, $urandom};
        else
            id = id_pool[$urandom_range(0, POOL - 1)];
        send_item(k, id, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), 1'b0, '0);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (reply_words.size() == 0)
            begin
                $error("result word with nothing owed");
                fail_count++;
            end
            else
            begin
                want_word = reply_words.pop_front();
                check_field("status", want_word.status, status);
                check_field("notice", want_word.notice, notice);
                check_field("peer_id", want_word.peer_id, peer_id);
                check_field("receive_total", want_word.receive_total, receive_total);
                check_field("retransmit_total", want_word.retransmit_total, retransmit_total);
                check_field("dead_flag", want_word.dead_flag, dead_flag);
                check_field("changed", want_word.changed, changed);
                check_field("last_result", want_word.last_result, last_result);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int      ph;
        int      j;
        int      n_items;
        int      add_w;
        result_t quiet;
        rst_n     = 1'b0;
        start     = 1'b0;
        kind      = KIND_TICK;
        node_id   = '0;
        node_type = '0;
        parse_ok  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_OWN_ID;
        cfg_wdata = '0;

        cur_own_id    = '0;
        cur_type_mask = '1;
        cur_dead_to   = DEAD_TIMEOUT_RST;
        cur_clear_to  = CLEAR_TIMEOUT_RST;
        tnow          = '0;
        for (j = 0; j < NODES; j++)
        begin
            slot_valid[j]   = 1'b0;
            slot_id[j]      = '0;
            slot_dead[j]    = 1'b0;
            slot_last_rx[j] = '0;
            slot_rx[j]      = '0;
            slot_retx[j]    = '0;
            slot_stats[j]   = 1'b0;
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        id_pool[0] = ID_MAX;
        id_pool[1] = ID_MIN;
        id_pool[2] = ID_ALL_ONES;
        id_pool[3] = 64'd1;
        for (j = 4; j < POOL; j++)
            id_pool[j] = {$urandom, $urandom};

        write_reg(REG_KNOWN_TYPES, ~(64'd1 << HIDDEN_TYPE));

        quiet = mk_word(STATUS_OK, NOTICE_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b1);
        script_row(KIND_TICK,       '0,          6'd0,  1'b0, 1'b1, quiet);
        script_row(KIND_DEAD_CHECK, '0,          6'd0,  1'b0, 1'b1, quiet);
        script_row(KIND_RECEIVE,    64'd5,       6'd0,  1'b0, 1'b1,
                   mk_word(STATUS_UNKNOWN_NODE, NOTICE_NONE, 64'd5, '0, '0, 1'b0, 1'b0, 1'b1));
        script_row(KIND_ADD,        '0,          6'd0,  1'b0, 1'b1,
                   mk_word(STATUS_OWN_ID, NOTICE_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b1));
        script_row(KIND_ADD,        ID_MAX,      6'd63, 1'b0, 1'b1,
                   mk_word(STATUS_OK, NOTICE_INCLUDE, ID_MAX, '0, '0, 1'b0, 1'b1, 1'b1));
        script_row(KIND_ADD,        ID_MIN,      6'd0,  1'b1, 1'b1,
                   mk_word(STATUS_OK, NOTICE_INCLUDE, ID_MIN, '0, '0, 1'b0, 1'b1, 1'b1));
        script_row(KIND_ADD,        ID_MAX,      6'd7,  1'b0, 1'b1,
                   mk_word(STATUS_DUPLICATE, NOTICE_NONE, ID_MAX, '0, '0, 1'b0, 1'b0, 1'b1));
        script_row(KIND_ADD,        ID_ALL_ONES, 6'(HIDDEN_TYPE), 1'b0, 1'b1,
                   mk_word(STATUS_UNKNOWN_TYPE, NOTICE_NONE, ID_ALL_ONES, '0, '0,
                           1'b0, 1'b0, 1'b1));
        script_row(KIND_ADD,        ID_ALL_ONES, 6'd62, 1'b0, 1'b1,
                   mk_word(STATUS_OK, NOTICE_INCLUDE, ID_ALL_ONES, '0, '0, 1'b0, 1'b1, 1'b1));
        script_row(KIND_RECEIVE,    ID_MAX,      6'd0,  1'b0, 1'b0, '0);
        script_row(KIND_RETRANSMIT, ID_MIN,      6'd0,  1'b0, 1'b0, '0);
        script_row(KIND_STATS,      ID_MAX,      6'd0,  1'b1, 1'b0, '0);
        script_row(KIND_STATS,      ID_MAX,      6'd0,  1'b0, 1'b0, '0);
        script_row(KIND_SET_DEAD,   ID_MIN,      6'd0,  1'b0, 1'b0, '0);
        script_row(KIND_RECEIVE,    ID_MIN,      6'd0,  1'b0, 1'b0, '0);
        script_row(KIND_STATS,      ID_MIN,      6'd0,  1'b1, 1'b0, '0);
        script_row(KIND_SET_DEAD,   ID_MIN,      6'd0,  1'b0, 1'b0, '0);
        script_row(KIND_RETRANSMIT, 64'd5,       6'd0,  1'b0, 1'b1,
                   mk_word(STATUS_UNKNOWN_NODE, NOTICE_NONE, 64'd5, '0, '0, 1'b0, 1'b0, 1'b1));
        script_row(KIND_SET_DEAD,   64'd5,       6'd0,  1'b0, 1'b1,
                   mk_word(STATUS_UNKNOWN_NODE, NOTICE_NONE, 64'd5, '0, '0, 1'b0, 1'b0, 1'b1));
        script_row(KIND_STATS,      64'd5,       6'd0,  1'b1, 1'b1,
                   mk_word(STATUS_UNKNOWN_NODE, NOTICE_NONE, 64'd5, '0, '0, 1'b0, 1'b0, 1'b1));
        script_row(KIND_UNUSED,     ID_ALL_ONES, 6'd63, 1'b1, 1'b1, quiet);
        script_row(KIND_TICK,       ID_ALL_ONES, 6'd63, 1'b1, 1'b1, quiet);
        script_row(KIND_DEAD_CHECK, '0,          6'd0,  1'b0, 1'b0, '0);

        foreach (script[j])
            send_item(script[j].k, script[j].id, script[j].ty, script[j].ok,
                      script[j].typed, script[j].want);

        for (ph = 0; ph < 5; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    write_reg(REG_OWN_ID, id_pool[4]);
                    write_reg(REG_KNOWN_TYPES, {$urandom, $urandom});
                    write_reg(REG_DEAD_TIMEOUT, 64'd65535);
                    write_reg(REG_CLEAR_TIMEOUT, 64'd1048575);
                    add_w   = 8;
                    n_items = 120;
                end
                1:
                begin
                    write_reg(REG_OWN_ID, {$urandom, $urandom});
                    write_reg(REG_KNOWN_TYPES, {$urandom, $urandom} | {$urandom, $urandom});
                    write_reg(REG_DEAD_TIMEOUT, 64'($urandom_range(20, 60)));
                    write_reg(REG_CLEAR_TIMEOUT, 64'($urandom_range(60, 200)));
                    add_w   = 8;
                    n_items = 110;
                end
                2:
                begin
                    write_reg(REG_OWN_ID, '0);
                    write_reg(REG_KNOWN_TYPES, {$urandom, $urandom});
                    write_reg(REG_DEAD_TIMEOUT, 64'd1);
                    write_reg(REG_CLEAR_TIMEOUT, 64'd1);
                    add_w   = 5;
                    n_items = 80;
                end
                3:
                begin
                    // all types known and many adds: fill the table
                    write_reg(REG_OWN_ID, ID_MIN);
                    write_reg(REG_KNOWN_TYPES, ID_ALL_ONES);
                    write_reg(REG_DEAD_TIMEOUT, 64'($urandom_range(2, 30)));
                    write_reg(REG_CLEAR_TIMEOUT, 64'($urandom_range(2, 60)));
                    add_w   = 35;
                    n_items = 80;
                end
                default:
                begin
                    write_reg(REG_OWN_ID, id_pool[$urandom_range(0, POOL - 1)]);
                    write_reg(REG_KNOWN_TYPES, '0);
                    write_reg(REG_DEAD_TIMEOUT, 64'($urandom_range(1, 65535)));
                    write_reg(REG_CLEAR_TIMEOUT, 64'($urandom_range(1, 1048575)));
                    add_w   = 10;
                    n_items = 80;
                end
            endcase
            for (j = 0; j < n_items; j++)
            begin
                // switch between back-to-back stretches and random gaps
                if (j % 24 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                random_item(add_w);
            end
        end

        settle();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
